>>> design/ssd_pkg.sv
// Shared types and constants for the descending selection sort block.
// Holds the item word, the controller command and status structs.
// No dependencies.
package ssd_pkg;

    localparam int DEFAULT_MAX_ITEMS = 16;
    localparam int KEY_W             = 16;
    localparam int TAG_W             = 8;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } ssd_item_t;

    typedef struct packed {
        logic store;
        logic start;
        logic rd_pos;
        logic cap_pos;
        logic scan_step;
        logic swap_a;
        logic swap_b;
        logic emit_rd;
        logic emit_load;
    } ssd_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic scan_done;
        logic pos_last;
        logic emit_last;
        logic out_free;
    } ssd_sts_t;

endpackage

>>> design/ssd_ifs.sv
// Valid/ready channel interfaces for the input items and the sorted results.
// Depends on ssd_pkg for the field widths.
interface ssd_in_if
    import ssd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] item_tag;
    logic             last_item;

    modport source (output valid, output sort_key, output item_tag, output last_item,
                    input ready);
    modport sink   (input valid, input sort_key, input item_tag, input last_item,
                    output ready);
endinterface

interface ssd_out_if
    import ssd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic             last_result;
    logic             overflowed;

    modport source (output valid, output sorted_key, output sorted_tag,
                    output last_result, output overflowed, input ready);
    modport sink   (input valid, input sorted_key, input sorted_tag,
                    input last_result, input overflowed, output ready);
endinterface

>>> design/ssd_ctrl.sv
// Sequencing state machine for loading, sorting and emitting a set.
// Depends on ssd_pkg for the command and status structs.
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  ssd_sts_t sts,
    output ssd_cmd_t cmd
);

    typedef enum logic [8:0] {
        ST_LOAD     = 9'b000000001,
        ST_START    = 9'b000000010,
        ST_RD_POS   = 9'b000000100,
        ST_CAP_POS  = 9'b000001000,
        ST_SCAN     = 9'b000010000,
        ST_SWAP_A   = 9'b000100000,
        ST_SWAP_B   = 9'b001000000,
        ST_EMIT_RD  = 9'b010000000,
        ST_EMIT_CAP = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = sts.n_lt2 ? ST_EMIT_RD : ST_RD_POS;
            end
            ST_RD_POS:
            begin
                cmd.rd_pos = 1'b1;
                state_next = ST_CAP_POS;
            end
            ST_CAP_POS:
            begin
                cmd.cap_pos = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_SWAP_A;
                end
            end
            ST_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                state_next = sts.pos_last ? ST_EMIT_RD : ST_RD_POS;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_CAP;
            end
            ST_EMIT_CAP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/ssd_datapath.sv
// Item store, selection scan registers and output register of the sorter.
// Depends on ssd_pkg and the ssd_out_if channel interface.
module ssd_datapath
    import ssd_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [KEY_W-1:0] in_key,
    input  logic [TAG_W-1:0] in_tag,
    input  ssd_cmd_t         cmd,
    output ssd_sts_t         sts,
    ssd_out_if.source        results
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W = CNT_W + 1;

    ssd_item_t key_tag_mem [MAX_ITEMS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    ssd_item_t        best_reg, best_next;
    ssd_item_t        pos_word_reg, pos_word_next;
    ssd_item_t        rd_word_reg;
    logic             out_vld_reg, out_vld_next;
    ssd_item_t        out_word_reg, out_word_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             full;
    logic             we;
    logic [IDX_W-1:0] waddr;
    ssd_item_t        wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;

    assign full          = (count_reg == CNT_W'(MAX_ITEMS));
    assign sts.n_lt2     = (count_reg < CNT_W'(2));
    assign sts.scan_done = (scan_reg == count_reg);
    assign sts.pos_last  = ((EXT_W'(pos_reg) + EXT_W'(2)) >= EXT_W'(count_reg));
    assign sts.emit_last = ((EXT_W'(k_reg) + EXT_W'(1)) == EXT_W'(count_reg));
    assign sts.out_free  = !out_vld_reg || results.ready;

    always_comb
    begin
        count_next    = count_reg;
        drop_next     = drop_reg;
        pos_next      = pos_reg;
        scan_next     = scan_reg;
        k_next        = k_reg;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        pos_word_next = pos_word_reg;
        out_vld_next  = out_vld_reg;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = best_reg;
        re            = 1'b0;
        raddr         = '0;

        if (cmd.store)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                we         = 1'b1;
                waddr      = count_reg[IDX_W-1:0];
                wdata.key  = in_key;
                wdata.tag  = in_tag;
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.start)
        begin
            pos_next = '0;
            k_next   = '0;
        end
        if (cmd.rd_pos)
        begin
            re        = 1'b1;
            raddr     = pos_reg[IDX_W-1:0];
            scan_next = pos_reg + CNT_W'(1);
        end
        if (cmd.cap_pos)
        begin
            pos_word_next = rd_word_reg;
            best_next     = rd_word_reg;
            best_idx_next = pos_reg[IDX_W-1:0];
            re            = 1'b1;
            raddr         = scan_reg[IDX_W-1:0];
            cmp_idx_next  = scan_reg[IDX_W-1:0];
            scan_next     = scan_reg + CNT_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (rd_word_reg.key > best_reg.key)
            begin
                best_next     = rd_word_reg;
                best_idx_next = cmp_idx_reg;
            end
            if (!sts.scan_done)
            begin
                re           = 1'b1;
                raddr        = scan_reg[IDX_W-1:0];
                cmp_idx_next = scan_reg[IDX_W-1:0];
                scan_next    = scan_reg + CNT_W'(1);
            end
        end
        if (cmd.swap_a)
        begin
            we    = 1'b1;
            waddr = pos_reg[IDX_W-1:0];
            wdata = best_reg;
        end
        if (cmd.swap_b)
        begin
            we       = 1'b1;
            waddr    = best_idx_reg;
            wdata    = pos_word_reg;
            pos_next = pos_reg + CNT_W'(1);
        end
        if (cmd.emit_rd)
        begin
            re    = 1'b1;
            raddr = k_reg[IDX_W-1:0];
        end

        if (cmd.emit_load)
        begin
            out_vld_next  = 1'b1;
            out_word_next = rd_word_reg;
            out_last_next = sts.emit_last;
            out_ovf_next  = sts.emit_last && drop_reg;
            k_next        = k_reg + CNT_W'(1);
            if (sts.emit_last)
            begin
                count_next = '0;
                drop_next  = 1'b0;
            end
        end
        else if (results.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_tag_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_word_reg <= key_tag_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        scan_reg     <= scan_next;
        k_reg        <= k_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        pos_word_reg <= pos_word_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign results.valid       = out_vld_reg;
    assign results.sorted_key  = out_word_reg.key;
    assign results.sorted_tag  = out_word_reg.tag;
    assign results.last_result = out_last_reg;
    assign results.overflowed  = out_ovf_reg;

endmodule

>>> design/selection_sort_descending.sv
// Loading accepts every valid beat; the last beat is followed by the start step.
// Sorting n items visits each position p below n - 1: it reads entry p, then the scan
// reads the entries above p one entry per cycle for the largest key and swaps it into p.
// Each result is read from the store, then loaded into the output register when free.
// Reset clears the item count, the drop flag and the output valid; the store holds
// no reset value and only entries written in the current set are read.
module selection_sort_descending
    import ssd_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
)
(
    input  logic      clk,
    input  logic      rst_n,
    ssd_in_if.sink    items,
    ssd_out_if.source results
);

    ssd_cmd_t cmd;
    ssd_sts_t sts;
    logic     in_ready;

    assign items.ready = in_ready;

    ssd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_last  (items.last_item),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssd_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_key  (items.sort_key),
        .in_tag  (items.item_tag),
        .cmd     (cmd),
        .sts     (sts),
        .results (results)
    );

endmodule
